FILE: design/fixed_point_alu_core_defines.svh
// Assertion macros for the fixed-point ALU core
`ifndef FIXED_POINT_ALU_CORE_DEFINES_SVH
`define FIXED_POINT_ALU_CORE_DEFINES_SVH
`define FPA_ASSERT_IMPL(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
`define FPA_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`endif

FILE: design/fpa_pkg.sv
// Shared types and command codes for the fixed-point ALU
package fpa_pkg;
   typedef enum logic [3:0] {
      CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_MUL = 4'd2, CMD_DIV = 4'd3,
      CMD_GT = 4'd4, CMD_LT = 4'd5, CMD_GE = 4'd6, CMD_LE = 4'd7,
      CMD_EQ = 4'd8, CMD_NE = 4'd9, CMD_MIN = 4'd10, CMD_MAX = 4'd11,
      CMD_INC = 4'd12, CMD_DEC = 4'd13, CMD_FROM_INT = 4'd14, CMD_TO_INT = 4'd15
   } cmd_type;
   localparam int IoWidth = 32;
endpackage

FILE: design/fpa_div_cell.sv
// Restoring-division cell: one quotient bit per advancing cycle; item rides along
module fpa_div_cell #(
   parameter int QW = 40,
   parameter int DW = 32,
   parameter int BIT = 0
) (
   input  logic          clock,
   input  logic          advance,
   input  logic [QW-1:0] num_in,
   input  logic [DW:0]   rem_in,
   input  logic [DW-1:0] den_in,
   output logic [QW-1:0] num_out,
   output logic [DW:0]   rem_out,
   output logic [DW-1:0] den_out
);
   logic [DW+1:0] trial;
   logic [DW+1:0] shifted;
   logic [QW-1:0] num_ff, num_in_c;
   logic [DW:0]   rem_ff, rem_in_c;
   logic [DW-1:0] den_ff;

   always_comb begin
      shifted  = {rem_in, num_in[BIT]};
      trial    = shifted - {2'b00, den_in};
      num_in_c = num_in;
      if (!trial[DW+1]) begin
         num_in_c[BIT] = 1'b1;
         rem_in_c      = trial[DW:0];
      end else begin
         num_in_c[BIT] = 1'b0;
         rem_in_c      = shifted[DW:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff <= num_in_c;
         rem_ff <= rem_in_c;
         den_ff <= den_in;
      end
   end

   assign num_out = num_ff;
   assign rem_out = rem_ff;
   assign den_out = den_ff;
endmodule

FILE: design/fpa_div_chain.sv
// Row of division cells, most significant quotient bit first
module fpa_div_chain #(
   parameter int QW = 40,
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          advance,
   input  logic [QW-1:0] num_in,
   input  logic [DW-1:0] den_in,
   output logic [QW-1:0] quo_out
);
   logic [QW-1:0] num_c [QW+1];
   logic [DW:0]   rem_c [QW+1];
   logic [DW-1:0] den_c [QW+1];

   assign num_c[0] = num_in;
   assign rem_c[0] = '0;
   assign den_c[0] = den_in;

   for (genvar i = 0; i < QW; i++) begin : g_cell
      fpa_div_cell #(.QW(QW), .DW(DW), .BIT(QW - 1 - i)) u_cell (
         .clock(clock), .advance(advance),
         .num_in(num_c[i]), .rem_in(rem_c[i]), .den_in(den_c[i]),
         .num_out(num_c[i+1]), .rem_out(rem_c[i+1]), .den_out(den_c[i+1])
      );
   end

   assign quo_out = num_c[QW];
endmodule

FILE: design/fixed_point_alu_core.sv
// Top level of the fixed-point ALU: stage row with division cell chain
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | command, operand_a, operand_b
//  rsp     | out       | rsp_valid/rsp_ready  | result_value, compare_true, divide_by_zero
// Each item passes stage 0, the division cell row (one quotient bit per cell)
// and the output register. One transaction enters per cycle; all stages
// advance together whenever the output register is empty or being taken.
// Synchronous reset clears the stage valid bits; payload is not reset.
// A stalled output freezes the whole row and drops req_ready.
module fixed_point_alu_core #(
   parameter int FRACTION_BITS = 8,
   parameter int WORD_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [3:0]                  req_command,
   input  logic signed [fpa_pkg::IoWidth-1:0] req_operand_a,
   input  logic signed [fpa_pkg::IoWidth-1:0] req_operand_b,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [fpa_pkg::IoWidth-1:0] rsp_result_value,
   output logic                        rsp_compare_true,
   output logic                        rsp_divide_by_zero
);
   import fpa_pkg::*;
`include "fixed_point_alu_core_defines.svh"

   localparam int W  = WORD_WIDTH;
   localparam int F  = FRACTION_BITS;
   localparam int QW = W + F;
   localparam int D  = QW + 2;

   logic advance;
   logic [D-1:0] vld_ff;
   logic [D-1:0] vld_in;

   // stage 0: decode and simple ops, multiplier product register
   logic [W-1:0] a, b, ma, mb;
   logic         an, bn, lt_ab, lt_ba;
   logic [W-1:0] simple;
   logic         cmp;
   cmd_type      cmd;

   always_comb begin
      cmd = cmd_type'(req_command);
      a  = W'(req_operand_a);
      b  = W'(req_operand_b);
      an = a[W-1];
      bn = b[W-1];
      ma = an ? -a : a;
      mb = bn ? -b : b;
      lt_ab = $signed(a) < $signed(b);
      lt_ba = $signed(b) < $signed(a);
      simple = '0;
      cmp = 1'b0;
      unique case (cmd)
         CMD_ADD:      simple = a + b;
         CMD_SUB:      simple = a - b;
         CMD_GT:       cmp = lt_ba;
         CMD_LT:       cmp = lt_ab;
         CMD_GE:       cmp = !lt_ab;
         CMD_LE:       cmp = !lt_ba;
         CMD_EQ:       cmp = a == b;
         CMD_NE:       cmp = a != b;
         CMD_MIN:      simple = lt_ab ? a : b;
         CMD_MAX:      simple = lt_ba ? a : b;
         CMD_INC:      simple = a + W'(1);
         CMD_DEC:      simple = a - W'(1);
         CMD_FROM_INT: simple = a << F;
         CMD_TO_INT:   simple = W'($signed(a) >>> F);
         default:      simple = '0;
      endcase
   end

   logic          s0_mul_ff, s0_div_ff, s0_neg_ff, s0_dz_ff, s0_cmp_ff;
   logic [W-1:0]  s0_simple_ff, s0_mb_ff;
   logic [QW-1:0] s0_num_ff;
   logic [2*W-1:0] s0_prod_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_mul_ff    <= cmd == CMD_MUL;
         s0_div_ff    <= cmd == CMD_DIV && b != '0;
         s0_dz_ff     <= cmd == CMD_DIV && b == '0;
         s0_neg_ff    <= an ^ bn;
         s0_cmp_ff    <= cmp;
         s0_simple_ff <= simple;
         s0_mb_ff     <= mb;
         s0_num_ff    <= QW'(ma) << F;
         s0_prod_ff   <= (2*W)'(ma) * (2*W)'(mb);
      end
   end

   // side data rides alongside the division chain
   logic [W-1:0] side_val [QW+1];
   logic         side_div [QW+1], side_neg [QW+1], side_dz [QW+1], side_cmp [QW+1];
   logic [W-1:0] mv;

   assign mv          = W'(s0_prod_ff >> F);
   assign side_val[0] = s0_mul_ff ? (s0_neg_ff ? -mv : mv) : s0_simple_ff;
   assign side_div[0] = s0_div_ff;
   assign side_neg[0] = s0_neg_ff;
   assign side_dz[0]  = s0_dz_ff;
   assign side_cmp[0] = s0_cmp_ff;

   for (genvar i = 0; i < QW; i++) begin : g_side
      logic [W-1:0] val_ff;
      logic         div_ff, neg_ff, dz_ff, cmp_ff;
      always_ff @(posedge clock) begin
         if (advance) begin
            val_ff <= side_val[i];
            div_ff <= side_div[i];
            neg_ff <= side_neg[i];
            dz_ff  <= side_dz[i];
            cmp_ff <= side_cmp[i];
         end
      end
      assign side_val[i+1] = val_ff;
      assign side_div[i+1] = div_ff;
      assign side_neg[i+1] = neg_ff;
      assign side_dz[i+1]  = dz_ff;
      assign side_cmp[i+1] = cmp_ff;
   end

   logic [QW-1:0] quo;
   fpa_div_chain #(.QW(QW), .DW(W)) u_div (
      .clock(clock), .advance(advance),
      .num_in(s0_num_ff), .den_in(s0_mb_ff), .quo_out(quo)
   );

   // output register
   logic [W-1:0] qv, fin;
   logic [W-1:0] out_val_ff;
   logic         out_cmp_ff, out_dz_ff;

   always_comb begin
      qv  = quo[W-1:0];
      fin = side_div[QW] ? (side_neg[QW] ? -qv : qv) : side_val[QW];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_val_ff <= fin;
         out_cmp_ff <= side_cmp[QW];
         out_dz_ff  <= side_dz[QW];
      end
   end

   assign advance = !vld_ff[D-1] || rsp_ready;
   assign vld_in  = {vld_ff[D-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready          = advance;
   assign rsp_valid          = vld_ff[D-1];
   assign rsp_result_value   = IoWidth'($signed(out_val_ff));
   assign rsp_compare_true   = out_cmp_ff;
   assign rsp_divide_by_zero = out_dz_ff;

   `FPA_ASSERT_IMPL(a_stall_ready, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   `FPA_ASSERT_IMPL(a_flag_excl, clock, reset, rsp_valid, !(rsp_compare_true && rsp_divide_by_zero))
   `FPA_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_value))
   `FPA_ASSERT_IMPL(a_dz_zero, clock, reset, rsp_valid && rsp_divide_by_zero, rsp_result_value == '0)
endmodule
